### rtl/uss_pkg.sv
`default_nettype none

package uss_pkg;

   // request commands
   localparam logic [1:0] CMD_APPEND = 2'd0;
   localparam logic [1:0] CMD_FLUSH  = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   // reason a sentence was emitted
   localparam logic [1:0] KIND_DELIM  = 2'd0;
   localparam logic [1:0] KIND_FORCED = 2'd1;
   localparam logic [1:0] KIND_FLUSH  = 2'd2;

   localparam int unsigned CHUNK_BYTES = 8;
   localparam int unsigned NBYTES_W    = 4;

   localparam logic [6:0] CUT_POINT_RESET = 7'd90;

   localparam logic [7:0] BYTE_LF     = 8'h0A;
   localparam logic [7:0] BYTE_CR     = 8'h0D;
   localparam logic [7:0] BYTE_BANG   = 8'h21;
   localparam logic [7:0] BYTE_QUERY  = 8'h3F;
   localparam logic [7:0] BYTE_STOP   = 8'h2E;
   localparam logic [7:0] BYTE_COMMA  = 8'h2C;
   localparam logic [7:0] LEAD_CJK    = 8'hE3;
   localparam logic [7:0] LEAD_FW     = 8'hEF;
   localparam logic [7:0] LEAD_PUNCT  = 8'hE2;
   localparam logic [7:0] MID_80      = 8'h80;
   localparam logic [7:0] MID_BC      = 8'hBC;
   localparam logic [7:0] END_81      = 8'h81;
   localparam logic [7:0] END_82      = 8'h82;
   localparam logic [7:0] END_9F      = 8'h9F;
   localparam logic [7:0] END_A6      = 8'hA6;
   localparam logic [1:0] CONT_TAG    = 2'b10;

   typedef struct packed {
      logic       append;
      logic       clear;
      logic       cut_init;
      logic       cut_inc;
      logic       scan_rd;
      logic       emit_start;
      logic       emit_from_cut;
      logic [1:0] kind;
      logic       emit_rd;
      logic       emit_cap;
      logic       chunk_take;
      logic       emit_end;
   } dp_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic delim_hit;
      logic at_limit;
      logic cut_below;
      logic cont_byte;
      logic chunk_done;
      logic all_sent;
   } dp_status_type;

   function automatic logic is_single_delim(input logic [7:0] c);
      return (c == BYTE_LF) || (c == BYTE_CR) || (c == BYTE_BANG) ||
             (c == BYTE_QUERY) || (c == BYTE_STOP) || (c == BYTE_COMMA);
   endfunction

   function automatic logic is_triple_delim(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
      return ((a == LEAD_CJK) && (b == MID_80) && ((c == END_81) || (c == END_82))) ||
             ((a == LEAD_FW) && (b == MID_BC) && ((c == END_81) || (c == END_9F))) ||
             ((a == LEAD_PUNCT) && (b == MID_80) && (c == END_A6));
   endfunction

endpackage

`default_nettype wire

### rtl/utf8_sentence_splitter.sv
`default_nettype none

// UTF-8 sentence splitter. Text bytes arrive as append transactions and are
// held in a ring buffer of SPLIT_LIMIT bytes (one single-port-read RAM). When
// the byte just appended completes a delimiter (LF, CR, ! ? . , or the
// three-byte ideographic comma/full stop, fullwidth ! and ?, or ellipsis) the
// whole buffer leaves as response transactions of up to eight bytes, first
// byte in bits 7..0, last_of_sentence on the final one. Once SPLIT_LIMIT bytes
// gather with no delimiter a forced cut is made at csr cut_point (0 acts as 1),
// moved forward past UTF-8 continuation bytes; the rest stays buffered. Flush
// emits the buffer, clear drops it, command 3 is ignored. An append is accepted
// and then checked for a delimiter. Emitting reads each byte through the single
// RAM read port, whose output is registered, and captures it into the chunk; a
// forced cut first steps the cut point past any UTF-8 continuation bytes it
// finds there. One request is processed at a time; req_ready is low until
// all of its responses have been taken. Write cut_point only while idle.

module utf8_sentence_splitter #(
   parameter int unsigned SPLIT_LIMIT = 120
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [7:0]  req_data_byte,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [63:0] rsp_chunk,
   output logic      [3:0]  rsp_chunk_bytes,
   output logic             rsp_last_of_sentence,
   output logic      [1:0]  rsp_cut_kind,
   // cut_point register
   input  wire logic        csr_write_enable,
   input  wire logic [6:0]  csr_write_data
);
   import uss_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencing: append/check, forced-cut scan, byte-by-byte chunk assembly
   uss_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .status      (status),
      .cmd         (cmd)
   );

   // buffer, pointers, delimiter tail and the response register
   uss_dp #(
      .SPLIT_LIMIT (SPLIT_LIMIT)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_data_byte        (req_data_byte),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .cmd                  (cmd),
      .status               (status),
      .rsp_chunk            (rsp_chunk),
      .rsp_chunk_bytes      (rsp_chunk_bytes),
      .rsp_last_of_sentence (rsp_last_of_sentence),
      .rsp_cut_kind         (rsp_cut_kind)
   );

endmodule

`default_nettype wire

### rtl/uss_ram.sv
`default_nettype none

module uss_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 120,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/uss_dp.sv
`default_nettype none

module uss_dp #(
   parameter int unsigned SPLIT_LIMIT = 120
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [7:0]            req_data_byte,
   input  wire logic                  csr_write_enable,
   input  wire logic [6:0]            csr_write_data,
   input  wire uss_pkg::dp_cmd_type   cmd,
   output uss_pkg::dp_status_type     status,
   output logic      [63:0]           rsp_chunk,
   output logic      [3:0]            rsp_chunk_bytes,
   output logic                       rsp_last_of_sentence,
   output logic      [1:0]            rsp_cut_kind
);
   import uss_pkg::*;

   localparam int unsigned AW   = (SPLIT_LIMIT > 1) ? $clog2(SPLIT_LIMIT) : 1;
   localparam int unsigned CW   = $clog2(SPLIT_LIMIT + 1);
   localparam int unsigned SW   = CW + 1;
   localparam int unsigned CMPW = (CW > 7) ? CW : 7;

   logic [AW-1:0]       head_ff, head_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       cut_ff, cut_in;
   logic [CW-1:0]       len_ff, len_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [NBYTES_W-1:0] nbytes_ff, nbytes_in;
   logic [63:0]         chunk_ff, chunk_in;
   logic [1:0]          kind_ff, kind_in;
   logic                last_ff, last_in;
   logic [7:0]          tail0_ff, tail1_ff, tail2_ff;
   logic [7:0]          tail0_in, tail1_in, tail2_in;
   logic [6:0]          cut_point_ff, cut_point_in;

   logic [AW-1:0]       wr_addr, rd_addr;
   logic [7:0]          rd_data;
   logic                rd_en;
   logic [6:0]          cp_eff;
   logic [CW-1:0]       cut_start;
   logic [CW-1:0]       idx_next;

   // ring position of a byte offset from the head
   function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(off);
      if (sum >= SW'(SPLIT_LIMIT)) begin
         sum = sum - SW'(SPLIT_LIMIT);
      end
      return AW'(sum);
   endfunction

   assign wr_addr  = ring_addr(head_ff, count_ff);
   assign rd_addr  = ring_addr(head_ff, cmd.scan_rd ? cut_ff : idx_ff);
   assign rd_en    = cmd.scan_rd | cmd.emit_rd;
   assign idx_next = idx_ff + 1'b1;

   assign cp_eff    = (cut_point_ff == 7'd0) ? 7'd1 : cut_point_ff;
   assign cut_start = (CMPW'(cp_eff) > CMPW'(count_ff)) ? count_ff : CW'(cp_eff);

   uss_ram #(
      .WIDTH (8),
      .DEPTH (SPLIT_LIMIT)
   ) u_buf (
      .clock   (clock),
      .wr_en   (cmd.append),
      .wr_addr (wr_addr),
      .wr_data (req_data_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      cut_in       = cut_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      nbytes_in    = nbytes_ff;
      chunk_in     = chunk_ff;
      kind_in      = kind_ff;
      last_in      = last_ff;
      tail0_in     = tail0_ff;
      tail1_in     = tail1_ff;
      tail2_in     = tail2_ff;
      cut_point_in = csr_write_enable ? csr_write_data : cut_point_ff;

      if (cmd.append) begin
         count_in = count_ff + 1'b1;
         tail0_in = req_data_byte;
         tail1_in = tail0_ff;
         tail2_in = tail1_ff;
      end
      if (cmd.clear) begin
         count_in = '0;
      end
      if (cmd.cut_init) begin
         cut_in = cut_start;
      end
      if (cmd.cut_inc) begin
         cut_in = cut_ff + 1'b1;
      end
      if (cmd.emit_start) begin
         len_in    = cmd.emit_from_cut ? cut_ff : count_ff;
         idx_in    = '0;
         nbytes_in = '0;
         chunk_in  = '0;
         kind_in   = cmd.kind;
         last_in   = 1'b0;
      end
      if (cmd.emit_cap) begin
         chunk_in  = chunk_ff | (64'(rd_data) << {nbytes_ff[2:0], 3'b000});
         nbytes_in = nbytes_ff + 1'b1;
         idx_in    = idx_next;
         last_in   = (idx_next == len_ff);
      end
      if (cmd.chunk_take) begin
         chunk_in  = '0;
         nbytes_in = '0;
      end
      if (cmd.emit_end) begin
         head_in  = ring_addr(head_ff, len_ff);
         count_in = count_ff - len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         cut_point_ff <= CUT_POINT_RESET;
         nbytes_ff    <= '0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         cut_point_ff <= cut_point_in;
         nbytes_ff    <= nbytes_in;
      end
      cut_ff   <= cut_in;
      len_ff   <= len_in;
      idx_ff   <= idx_in;
      chunk_ff <= chunk_in;
      kind_ff  <= kind_in;
      last_ff  <= last_in;
      tail0_ff <= tail0_in;
      tail1_ff <= tail1_in;
      tail2_ff <= tail2_in;
   end

   always_comb begin
      status.count_zero = (count_ff == '0);
      status.delim_hit  = is_single_delim(tail0_ff) ||
                          ((count_ff >= CW'(3)) && is_triple_delim(tail2_ff, tail1_ff, tail0_ff));
      status.at_limit   = (count_ff == CW'(SPLIT_LIMIT));
      status.cut_below  = (cut_ff < count_ff);
      status.cont_byte  = (rd_data[7:6] == CONT_TAG);
      status.chunk_done = (nbytes_ff == NBYTES_W'(CHUNK_BYTES - 1)) || (idx_next == len_ff);
      status.all_sent   = (idx_ff == len_ff);
   end

   assign rsp_chunk            = chunk_ff;
   assign rsp_chunk_bytes      = nbytes_ff;
   assign rsp_last_of_sentence = last_ff;
   assign rsp_cut_kind         = kind_ff;

endmodule

`default_nettype wire

### rtl/uss_ctrl.sv
`default_nettype none

module uss_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic [1:0]            req_command,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire uss_pkg::dp_status_type status,
   output uss_pkg::dp_cmd_type        cmd
);
   import uss_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_EMIT_RD,
      S_EMIT_CAP,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      take;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign take      = req_valid & req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (take) begin
               case (req_command)
                  CMD_APPEND: begin
                     cmd.append = 1'b1;
                     state_in   = S_CHECK;
                  end
                  CMD_FLUSH: begin
                     if (!status.count_zero) begin
                        cmd.emit_start = 1'b1;
                        cmd.kind       = KIND_FLUSH;
                        state_in       = S_EMIT_RD;
                     end
                  end
                  CMD_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CHECK: begin
            if (status.delim_hit) begin
               cmd.emit_start = 1'b1;
               cmd.kind       = KIND_DELIM;
               state_in       = S_EMIT_RD;
            end else if (status.at_limit) begin
               cmd.cut_init = 1'b1;
               state_in     = S_SCAN_RD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCAN_RD: begin
            if (status.cut_below) begin
               cmd.scan_rd = 1'b1;
               state_in    = S_SCAN_CHK;
            end else begin
               cmd.emit_start    = 1'b1;
               cmd.emit_from_cut = 1'b1;
               cmd.kind          = KIND_FORCED;
               state_in          = S_EMIT_RD;
            end
         end
         S_SCAN_CHK: begin
            if (status.cont_byte) begin
               cmd.cut_inc = 1'b1;
               state_in    = S_SCAN_RD;
            end else begin
               cmd.emit_start    = 1'b1;
               cmd.emit_from_cut = 1'b1;
               cmd.kind          = KIND_FORCED;
               state_in          = S_EMIT_RD;
            end
         end
         S_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = S_EMIT_CAP;
         end
         S_EMIT_CAP: begin
            cmd.emit_cap = 1'b1;
            state_in     = status.chunk_done ? S_OUT : S_EMIT_RD;
         end
         S_OUT: begin
            if (rsp_ready) begin
               cmd.chunk_take = 1'b1;
               if (status.all_sent) begin
                  cmd.emit_end = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire
